/* rtl/dism_pkg.sv */
// Package for the implode size meter: codes, phases, handshake structs and
// the fixed canonical code tables, built at elaboration from run-length lists.
// No dependencies.
package dism_pkg;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEADER = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_CODE   = 3'd3,
        ST_FAR    = 3'd4,
        ST_LIMIT  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        PH_HEAD0, PH_HEAD1, PH_FLAG, PH_RAWLIT, PH_HLIT, PH_HLEN, PH_HDIST,
        PH_LEXTRA, PH_DLOW
    } t_phase;

    typedef enum logic [1:0] {CS_IDLE, CS_RUN} t_ctrl_state;

    typedef enum logic [1:0] {TAB_LIT, TAB_LEN, TAB_DIST} t_table;

    typedef struct packed {
        logic load;
        logic step;
        logic restart;
    } t_dp_cmd;

    typedef struct packed {
        logic    stop;   // needs more bits
        logic    done;   // result reached
        t_status code;
    } t_dp_stat;

    localparam logic [9:0]  END_LENGTH   = 10'd519;
    localparam logic [29:0] LIMIT_RESET  = 30'd536870912;
    localparam int          CNT_DEPTH    = 17;
    localparam int          LIT_RLE_N    = 98;
    localparam int          LEN_RLE_N    = 6;
    localparam int          DIST_RLE_N   = 7;

    localparam logic [7:0] LIT_RLE [LIT_RLE_N] = '{
        8'd11, 8'd124, 8'd8, 8'd7, 8'd28, 8'd7, 8'd188, 8'd13, 8'd76, 8'd4, 8'd10, 8'd8,
        8'd12, 8'd10, 8'd12, 8'd10, 8'd8, 8'd23, 8'd8, 8'd9, 8'd7, 8'd6, 8'd7, 8'd8,
        8'd7, 8'd6, 8'd55, 8'd8, 8'd23, 8'd24, 8'd12, 8'd11, 8'd7, 8'd9, 8'd11, 8'd12,
        8'd6, 8'd7, 8'd22, 8'd5, 8'd7, 8'd24, 8'd6, 8'd11, 8'd9, 8'd6, 8'd7, 8'd22,
        8'd7, 8'd11, 8'd38, 8'd7, 8'd9, 8'd8, 8'd25, 8'd11, 8'd8, 8'd11, 8'd9, 8'd12,
        8'd8, 8'd12, 8'd5, 8'd38, 8'd5, 8'd38, 8'd5, 8'd11, 8'd7, 8'd5, 8'd6, 8'd21,
        8'd6, 8'd10, 8'd53, 8'd8, 8'd7, 8'd24, 8'd10, 8'd27, 8'd44, 8'd253, 8'd253,
        8'd253, 8'd252, 8'd252, 8'd252, 8'd13, 8'd12, 8'd45, 8'd12, 8'd45, 8'd12, 8'd61,
        8'd12, 8'd45, 8'd44, 8'd173};
    localparam logic [7:0] LEN_RLE [LEN_RLE_N] = '{8'd2, 8'd35, 8'd36, 8'd53, 8'd38, 8'd23};
    localparam logic [7:0] DIST_RLE [DIST_RLE_N] =
        '{8'd2, 8'd20, 8'd53, 8'd230, 8'd247, 8'd151, 8'd248};

    localparam logic [9:0] LEN_BASE [16] = '{10'd3, 10'd2, 10'd4, 10'd5, 10'd6, 10'd7,
        10'd8, 10'd9, 10'd10, 10'd12, 10'd16, 10'd24, 10'd40, 10'd72, 10'd136, 10'd264};
    localparam logic [3:0] LEN_EXTRA [16] = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};

    typedef logic [8:0] t_cnt_tab [CNT_DEPTH];
    typedef logic [7:0] t_sym_tab [256];
    typedef logic [3:0] t_len_list [256];

    function automatic int rle_n(input t_table t);
        case (t)
            TAB_LIT: return LIT_RLE_N;
            TAB_LEN: return LEN_RLE_N;
            default: return DIST_RLE_N;
        endcase
    endfunction

    function automatic logic [7:0] rle_at(input t_table t, input int i);
        case (t)
            TAB_LIT: return LIT_RLE[i];
            TAB_LEN: return LEN_RLE[i];
            default: return DIST_RLE[i];
        endcase
    endfunction

    function automatic int tab_cap(input t_table t);
        case (t)
            TAB_LIT: return 256;
            TAB_LEN: return 16;
            default: return 64;
        endcase
    endfunction

    // number of entries after expansion, clipped to the table capacity
    function automatic int tab_used(input t_table t);
        logic [7:0] e;
        int         i;
        int         k;
        k = 0;
        for (i = 0; i < rle_n(t); i++) begin
            e = rle_at(t, i);
            k += int'(e[7:4]) + 1;
        end
        return (k < tab_cap(t)) ? k : tab_cap(t);
    endfunction

    // expanded code lengths, clipped to the table capacity
    function automatic t_len_list expand(input t_table t);
        t_len_list lens;
        logic [7:0] e;
        int         i;
        int         j;
        int         k;
        k = 0;
        for (i = 0; i < 256; i++) lens[i] = 4'd0;
        for (i = 0; i < rle_n(t); i++) begin
            e = rle_at(t, i);
            for (j = 0; j <= int'(e[7:4]); j++) begin
                if (k < tab_cap(t)) begin
                    lens[k] = e[3:0];
                    k++;
                end
            end
        end
        return lens;
    endfunction

    function automatic t_cnt_tab build_counts(input t_table t, input int mb);
        t_len_list lens;
        t_cnt_tab  cnt;
        int        k;
        int        i;
        lens = expand(t);
        k    = tab_used(t);
        for (i = 0; i < CNT_DEPTH; i++) cnt[i] = 9'd0;
        for (i = 0; i < k; i++)
            if (int'(lens[i]) <= mb) cnt[lens[i]] = cnt[lens[i]] + 9'd1;
        return cnt;
    endfunction

    function automatic t_sym_tab build_syms(input t_table t, input int mb);
        t_len_list lens;
        t_cnt_tab  cnt;
        t_sym_tab  syms;
        int        offs [CNT_DEPTH + 1];
        int        k;
        int        i;
        int        l;
        lens = expand(t);
        k    = tab_used(t);
        cnt  = build_counts(t, mb);
        for (i = 0; i < 256; i++) syms[i] = 8'd0;
        for (i = 0; i <= CNT_DEPTH; i++) offs[i] = 0;
        for (l = 1; l < mb; l++) offs[l + 1] = offs[l] + int'(cnt[l]);
        for (i = 0; i < k; i++) begin
            l = int'(lens[i]);
            if (l != 0 && l <= mb) begin
                if (offs[l] < tab_cap(t)) syms[offs[l]] = 8'(i);
                offs[l]++;
            end
        end
        return syms;
    endfunction

endpackage

/* rtl/dism_in_if.sv */
// Input channel: one stream byte per item with its end marker.
// Depends on nothing.
interface dism_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_byte;

    modport source(output valid, output packed_byte, output last_byte, input ready);
    modport sink(input valid, input packed_byte, input last_byte, output ready);
endinterface

/* rtl/dism_out_if.sv */
// Result channel: status and measured size.
// Depends on nothing.
interface dism_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [29:0] produced_size;

    modport source(output valid, output status, output produced_size, input ready);
    modport sink(input valid, input status, input produced_size, output ready);
endinterface

/* rtl/dism_dp.sv */
// Decoder datapath: bit buffer, Huffman walker, length/distance and count.
// Performs one step of a decode phase per step command. Depends on dism_pkg.
module dism_dp #(
    parameter int MAX_CODE_BITS = 13,
    parameter int COUNT_WIDTH   = 30
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dism_pkg::t_dp_cmd      i_cmd,
    input  logic [7:0]             i_byte,
    input  logic                   i_cfg_we,
    input  logic [29:0]            i_cfg_wdata,
    output dism_pkg::t_dp_stat     o_stat,
    output logic [COUNT_WIDTH-1:0] o_count
);
    localparam int HW   = MAX_CODE_BITS + 2;
    localparam int SW   = $clog2(MAX_CODE_BITS + 2);
    localparam int SUMW = ((COUNT_WIDTH > 30) ? COUNT_WIDTH : 30) + 2;
    localparam dism_pkg::t_cnt_tab LIT_CNT  = dism_pkg::build_counts(dism_pkg::TAB_LIT,
                                                                     MAX_CODE_BITS);
    localparam dism_pkg::t_cnt_tab LEN_CNT  = dism_pkg::build_counts(dism_pkg::TAB_LEN,
                                                                     MAX_CODE_BITS);
    localparam dism_pkg::t_cnt_tab DIST_CNT = dism_pkg::build_counts(dism_pkg::TAB_DIST,
                                                                     MAX_CODE_BITS);
    localparam dism_pkg::t_sym_tab LIT_SYM  = dism_pkg::build_syms(dism_pkg::TAB_LIT,
                                                                   MAX_CODE_BITS);
    localparam dism_pkg::t_sym_tab LEN_SYM  = dism_pkg::build_syms(dism_pkg::TAB_LEN,
                                                                   MAX_CODE_BITS);
    localparam dism_pkg::t_sym_tab DIST_SYM = dism_pkg::build_syms(dism_pkg::TAB_DIST,
                                                                   MAX_CODE_BITS);
    localparam logic [9:0] LIT_USED  = 10'(dism_pkg::tab_used(dism_pkg::TAB_LIT));
    localparam logic [9:0] LEN_USED  = 10'(dism_pkg::tab_used(dism_pkg::TAB_LEN));
    localparam logic [9:0] DIST_USED = 10'(dism_pkg::tab_used(dism_pkg::TAB_DIST));

    logic [23:0]            r_buf, n_buf;
    logic [4:0]             r_held, n_held;
    dism_pkg::t_phase       r_phase, n_phase;
    logic [HW-1:0]          r_code, n_code;
    logic [HW-1:0]          r_first, n_first;
    logic [8:0]             r_index, n_index;
    logic [SW-1:0]          r_step, n_step;
    logic [9:0]             r_mlen, n_mlen;
    logic [5:0]             r_dhigh, n_dhigh;
    logic                   r_litc, n_litc;
    logic [2:0]             r_dict, n_dict;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [29:0]            r_limit;

    logic [3:0]      need;
    logic [7:0]      v8;
    logic [23:0]     shifted;
    logic [4:0]      load_at;
    logic [8:0]      cnt;
    logic [4:0]      step_idx;
    logic [HW-1:0]   code_bit;
    logic [HW-1:0]   first_sum;
    logic [8:0]      idx;
    logic [9:0]      used;
    logic [7:0]      sym;
    logic [SW-1:0]   step_inc;
    logic [9:0]      amount;
    logic [SUMW-1:0] psum;
    logic            over;
    logic [14:0]     back_dist;
    dism_pkg::t_dp_stat stat;

    assign load_at  = (r_held > 5'd16) ? 5'd16 : r_held;
    assign step_idx = 5'(r_step);
    assign step_inc = r_step + SW'(1);

    always_comb begin
        n_buf = r_buf; n_held = r_held; n_phase = r_phase;
        n_code = r_code; n_first = r_first; n_index = r_index; n_step = r_step;
        n_mlen = r_mlen; n_dhigh = r_dhigh; n_litc = r_litc; n_dict = r_dict;
        n_count = r_count;
        stat = '{stop: 1'b0, done: 1'b0, code: dism_pkg::ST_OK};

        case (r_phase)
            dism_pkg::PH_HEAD0, dism_pkg::PH_HEAD1, dism_pkg::PH_RAWLIT: need = 4'd8;
            dism_pkg::PH_LEXTRA: need = dism_pkg::LEN_EXTRA[r_mlen[3:0]];
            dism_pkg::PH_DLOW:   need = (r_mlen == 10'd2) ? 4'd2 : {1'b0, r_dict};
            default:             need = 4'd1;
        endcase
        v8      = r_buf[7:0] & 8'((9'd1 << need) - 9'd1);
        shifted = r_buf >> need;

        case (r_phase)
            dism_pkg::PH_HLIT: begin
                cnt = LIT_CNT[step_idx]; used = LIT_USED;
            end
            dism_pkg::PH_HLEN: begin
                cnt = LEN_CNT[step_idx]; used = LEN_USED;
            end
            default: begin
                cnt = DIST_CNT[step_idx]; used = DIST_USED;
            end
        endcase
        if (int'(r_step) > MAX_CODE_BITS) cnt = 9'd0;
        // code bits arrive inverted
        code_bit  = r_code | {{(HW-1){1'b0}}, ~r_buf[0]};
        first_sum = r_first + HW'(cnt);
        idx       = r_index + 9'(code_bit - r_first);
        case (r_phase)
            dism_pkg::PH_HLIT: sym = LIT_SYM[idx[7:0]];
            dism_pkg::PH_HLEN: sym = LEN_SYM[idx[7:0]];
            default:           sym = DIST_SYM[idx[7:0]];
        endcase

        amount    = (r_phase == dism_pkg::PH_DLOW) ? r_mlen : 10'd1;
        psum      = SUMW'(r_count) + SUMW'(amount);
        over      = (psum > SUMW'(r_limit)) || ((psum >> COUNT_WIDTH) != '0);
        back_dist = (15'(r_dhigh) << need) + 15'(v8) + 15'd1;

        if (5'(need) > r_held) begin
            stat.stop = 1'b1;
        end else begin
            n_buf  = shifted;
            n_held = r_held - 5'(need);
            case (r_phase)
                dism_pkg::PH_HEAD0: begin
                    if (v8 > 8'd1) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_HEADER;
                    end
                    n_litc  = v8[0];
                    n_phase = dism_pkg::PH_HEAD1;
                end
                dism_pkg::PH_HEAD1: begin
                    if (v8 < 8'd4 || v8 > 8'd6) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_HEADER;
                    end
                    n_dict  = v8[2:0];
                    n_phase = dism_pkg::PH_FLAG;
                end
                dism_pkg::PH_FLAG: begin
                    if (v8[0])       n_phase = dism_pkg::PH_HLEN;
                    else if (r_litc) n_phase = dism_pkg::PH_HLIT;
                    else             n_phase = dism_pkg::PH_RAWLIT;
                    n_code = '0; n_first = '0; n_index = '0; n_step = SW'(1);
                end
                dism_pkg::PH_RAWLIT: begin
                    if (over) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_LIMIT;
                    end
                    n_count = psum[COUNT_WIDTH-1:0];
                    n_phase = dism_pkg::PH_FLAG;
                end
                dism_pkg::PH_HLIT, dism_pkg::PH_HLEN, dism_pkg::PH_HDIST: begin
                    if (code_bit < first_sum) begin
                        n_code = '0; n_first = '0; n_index = '0; n_step = SW'(1);
                        if ({1'b0, idx} >= used) begin
                            stat.done = 1'b1; stat.code = dism_pkg::ST_CODE;
                        end else if (r_phase == dism_pkg::PH_HLIT) begin
                            if (over) begin
                                stat.done = 1'b1; stat.code = dism_pkg::ST_LIMIT;
                            end
                            n_count = psum[COUNT_WIDTH-1:0];
                            n_phase = dism_pkg::PH_FLAG;
                        end else if (r_phase == dism_pkg::PH_HLEN) begin
                            n_mlen  = {6'd0, sym[3:0]};
                            n_phase = dism_pkg::PH_LEXTRA;
                        end else begin
                            n_dhigh = sym[5:0];
                            n_phase = dism_pkg::PH_DLOW;
                        end
                    end else begin
                        n_index = r_index + cnt;
                        n_first = first_sum << 1;
                        n_code  = code_bit << 1;
                        n_step  = step_inc;
                        if (int'(step_inc) > MAX_CODE_BITS) begin
                            stat.done = 1'b1; stat.code = dism_pkg::ST_CODE;
                        end
                    end
                end
                dism_pkg::PH_LEXTRA: begin
                    n_mlen = dism_pkg::LEN_BASE[r_mlen[3:0]] + 10'(v8);
                    if (n_mlen == dism_pkg::END_LENGTH) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_OK;
                    end
                    n_code = '0; n_first = '0; n_index = '0; n_step = SW'(1);
                    n_phase = dism_pkg::PH_HDIST;
                end
                default: begin
                    if (SUMW'(back_dist) > SUMW'(r_count)) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_FAR;
                    end else if (over) begin
                        stat.done = 1'b1; stat.code = dism_pkg::ST_LIMIT;
                    end
                    n_count = psum[COUNT_WIDTH-1:0];
                    n_phase = dism_pkg::PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= dism_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_buf <= '0; r_held <= '0; r_phase <= dism_pkg::PH_HEAD0;
            r_code <= '0; r_first <= '0; r_index <= '0; r_step <= SW'(1);
            r_mlen <= '0; r_dhigh <= '0; r_litc <= 1'b0; r_dict <= '0;
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_buf  <= r_buf | (24'(i_byte) << load_at);
            r_held <= load_at + 5'd8;
        end else if (i_cmd.step && !stat.stop && !stat.done) begin
            r_buf <= n_buf; r_held <= n_held; r_phase <= n_phase;
            r_code <= n_code; r_first <= n_first; r_index <= n_index; r_step <= n_step;
            r_mlen <= n_mlen; r_dhigh <= n_dhigh; r_litc <= n_litc; r_dict <= n_dict;
            r_count <= n_count;
        end
    end

    assign o_stat  = stat;
    assign o_count = r_count;
endmodule

/* rtl/dism_ctrl.sv */
// Sequencing controller: takes bytes, runs decode steps, holds the result.
// Depends on dism_pkg.
module dism_ctrl #(
    parameter int COUNT_WIDTH = 30
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_last,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_status,
    output logic [29:0]            o_size,
    output dism_pkg::t_dp_cmd      o_cmd,
    input  dism_pkg::t_dp_stat     i_stat,
    input  logic [COUNT_WIDTH-1:0] i_count
);
    dism_pkg::t_ctrl_state r_state, n_state;
    logic                  r_skip, n_skip;
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    logic [2:0]            r_status, n_status;
    logic [29:0]           r_size, n_size;
    logic                  out_free;
    logic [COUNT_WIDTH+29:0] count_ext;

    assign out_free  = !r_out_valid || i_out_ready;
    assign count_ext = {30'd0, i_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dism_pkg::CS_IDLE;
            r_skip  <= 1'b0;
            r_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_skip  <= n_skip;
            r_last  <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_size   <= n_size;
    end

    always_comb begin
        n_state = r_state; n_skip = r_skip; n_last = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status = r_status; n_size = r_size;
        o_cmd = '{load: 1'b0, step: 1'b0, restart: 1'b0};
        o_in_ready = 1'b0;
        case (r_state)
            dism_pkg::CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_skip) begin
                        if (i_in_last) begin
                            o_cmd.restart = 1'b1;
                            n_skip = 1'b0;
                        end
                    end else begin
                        o_cmd.load = 1'b1;
                        n_last  = i_in_last;
                        n_state = dism_pkg::CS_RUN;
                    end
                end
            end
            dism_pkg::CS_RUN: begin
                if (out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.done || (i_stat.stop && r_last)) begin
                        n_out_valid = 1'b1;
                        n_status = i_stat.done ? i_stat.code : dism_pkg::ST_TRUNC;
                        n_size = (i_stat.done && i_stat.code == dism_pkg::ST_OK) ?
                                 count_ext[29:0] : 30'd0;
                        o_cmd.restart = r_last;
                        n_skip  = !r_last;
                        n_state = dism_pkg::CS_IDLE;
                    end else if (i_stat.stop) begin
                        n_state = dism_pkg::CS_IDLE;
                    end
                end
            end
            default: n_state = dism_pkg::CS_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_size      = r_size;
endmodule

/* rtl/dcl_implode_size_meter.sv */
// Implode stream size meter, top level.
// A byte is taken while idle, then the datapath steps once per decode phase
// (once per Huffman code bit) until a step finds too few bits, and the controller
// goes back to idle for the next byte. A result is registered and shows the cycle
// after it is found; while it waits, decode steps are held off.
// Reset (synchronous, active low) clears the decoder and sets the limit.
module dcl_implode_size_meter #(
    parameter int MAX_CODE_BITS = 13,
    parameter int COUNT_WIDTH   = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dism_in_if.sink     i_in,
    dism_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [29:0] i_cfg_wdata
);
    dism_pkg::t_dp_cmd      cmd;
    dism_pkg::t_dp_stat     stat;
    logic [COUNT_WIDTH-1:0] count;

    dism_dp #(.MAX_CODE_BITS(MAX_CODE_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_byte(i_in.packed_byte),
        .i_cfg_we, .i_cfg_wdata, .o_stat(stat), .o_count(count)
    );

    dism_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .i_in_last(i_in.last_byte), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_status(o_out.status), .o_size(o_out.produced_size),
        .o_cmd(cmd), .i_stat(stat), .i_count(count)
    );
endmodule

/* rtl/dism_checker.sv */
// Port-level checks for the size meter, bound to the top level.
// Depends on dism_pkg and dcl_implode_size_meter.
module dism_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [29:0] i_size
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("result dropped while stalled");

    a_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != dism_pkg::ST_OK |-> i_size == 30'd0)
        else $error("size given with error status");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_status <= dism_pkg::ST_LIMIT)
        else $error("status code out of range");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind dcl_implode_size_meter dism_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready), .i_status(o_out.status), .i_size(o_out.produced_size)
);
